[rtl/grid_spatial_hash_bins_assert.svh]
// Assertion macros used by the checker file of the grid spatial hash.
`ifndef GRID_SPATIAL_HASH_BINS_ASSERT_SVH
`define GRID_SPATIAL_HASH_BINS_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define GSH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define GSH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `GSH_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[rtl/gsh_pkg.sv]
package gsh_pkg;

  // Operation codes of a request.
  typedef enum logic [2:0] {
    FUNC_INSERT_POINT = 3'd0,
    FUNC_INSERT_BIN   = 3'd1,
    FUNC_REMOVE       = 3'd2,
    FUNC_MOVE         = 3'd3,
    FUNC_REGION_START = 3'd4,
    FUNC_FULL_START   = 3'd5,
    FUNC_NEXT         = 3'd6,
    FUNC_CLEAR        = 3'd7
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_PLACED     = 3'd1,
    STATUS_NOT_PLACED = 3'd2,
    STATUS_BIN_RANGE  = 3'd3,
    STATUS_DONE       = 3'd4
  } status_e;

  // Configuration register indexes.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_COLUMNS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROWS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_X_ORG   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_ORG   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_X_SCALE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_Y_SCALE = 3'd5;

  // Request payload.
  typedef struct packed {
    func_e              func;
    logic [7:0]         element_id;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [5:0]         bin_col;
    logic [5:0]         bin_row;
    logic [14:0]        half_width;
    logic [14:0]        half_height;
  } req_t;

  // Result payload.
  typedef struct packed {
    status_e    status;
    logic [7:0] found_element;
    logic [5:0] found_col;
    logic [5:0] found_row;
  } rsp_t;

endpackage

[rtl/gsh_ram.sv]
module gsh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/grid_spatial_hash_bins.sv]
// Uniform grid spatial hash. Pool elements are kept in doubly linked lists, one per
// bin, with bin heads in one memory and the per-element record (home bin, successor,
// predecessor) in another. Requests are taken one at a time; stall is high while a
// request is at work. Next uses the cached successor where it can and otherwise
// visits bins in turn. Both memories have a registered read port, and the one shared
// multiply and clamp unit maps coordinates to bins. After reset, and for a clear
// request, a pass writes every bin head and element record, during which no request
// is taken.
module grid_spatial_hash_bins #(
  parameter int POOL_SIZE   = 256,
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gsh_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gsh_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gsh_pkg::req_t                   in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gsh_pkg::rsp_t                   out_rsp_o
);
  import gsh_pkg::*;

  localparam int EW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int LW        = $clog2(POOL_SIZE + 1);
  localparam int CW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int BW        = CW + RW;
  localparam int BinDepth  = 2 ** BW;
  localparam int MW        = (CW > RW) ? CW : RW;
  localparam int ClrN      = (BinDepth > POOL_SIZE) ? BinDepth : POOL_SIZE;
  localparam int CLW       = $clog2(ClrN);
  localparam int CPW       = $clog2(MAX_COLUMNS + 2);
  localparam int RPW       = $clog2(MAX_ROWS + 1);

  // Element record: home bin, successor and predecessor links (0 is none).
  typedef struct packed {
    logic          placed;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [LW-1:0] succ;
    logic [LW-1:0] pred;
  } elem_t;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_ELEM   = 15'b000000000000100,
    S_MAP    = 15'b000000000001000,
    S_CLAMP  = 15'b000000000010000,
    S_UPV    = 15'b000000000100000,
    S_UNX    = 15'b000000001000000,
    S_UHEAD  = 15'b000000010000000,
    S_LRD    = 15'b000000100000000,
    S_LHEAD  = 15'b000001000000000,
    S_LFIX   = 15'b000010000000000,
    S_NADV   = 15'b000100000000000,
    S_NBIN   = 15'b001000000000000,
    S_NFOUND = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_e;

  function automatic logic [EW-1:0] lidx(input logic [LW-1:0] l);
    lidx = EW'(l - LW'(1));
  endfunction

  // Registers.
  state_e             state_q, state_d;
  req_t               req_q, req_d;
  elem_t              rec_q, rec_d;
  logic [LW-1:0]      head_q, head_d;
  logic [1:0]         map_idx_q, map_idx_d;
  logic [32:0]        prod_q, prod_d;
  logic [MW-1:0]      map_q [4];
  logic [MW-1:0]      map_d [4];
  rsp_t               res_q, res_d;
  rsp_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CW-1:0]      smin_col_q, smin_col_d, smax_col_q, smax_col_d;
  logic [RW-1:0]      smin_row_q, smin_row_d, smax_row_q, smax_row_d;
  logic [CPW-1:0]     scol_q, scol_d;
  logic [RPW-1:0]     srow_q, srow_d;
  logic [LW-1:0]      scur_q, scur_d, ssucc_q, ssucc_d;
  logic [CLW-1:0]     clr_cnt_q, clr_cnt_d;
  logic               clr_reply_q, clr_reply_d;
  logic [6:0]         columns_in_use_q, rows_in_use_q;
  logic signed [15:0] x_origin_q, y_origin_q;
  logic [15:0]        x_bins_per_unit_q, y_bins_per_unit_q;

  // Memory ports.
  logic          b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [LW-1:0] b_wdata, b_rdata;
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  elem_t         e_wdata, e_rdata;

  gsh_ram #(.Width(LW), .Depth(BinDepth)) u_heads (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  gsh_ram #(.Width($bits(elem_t)), .Depth(POOL_SIZE)) u_elems (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Last usable column and row.
  logic [CW-1:0] lcol;
  logic [RW-1:0] lrow;
  always_comb begin
    if (columns_in_use_q == 7'd0) begin
      lcol = '0;
    end else if (32'(columns_in_use_q) > MAX_COLUMNS) begin
      lcol = CW'(MAX_COLUMNS - 1);
    end else begin
      lcol = CW'(columns_in_use_q - 7'd1);
    end
    if (rows_in_use_q == 7'd0) begin
      lrow = '0;
    end else if (32'(rows_in_use_q) > MAX_ROWS) begin
      lrow = RW'(MAX_ROWS - 1);
    end else begin
      lrow = RW'(rows_in_use_q - 7'd1);
    end
  end

  // Shared coordinate to bin unit: offset times scale, then clamp.
  logic               is_region, is_y;
  logic signed [15:0] mp, morg;
  logic [14:0]        mh;
  logic [15:0]        mscale;
  logic signed [17:0] mpos;
  logic signed [18:0] moff;
  logic [32:0]        map_prod;
  logic [24:0]        mbin;
  logic [MW-1:0]      mlim, clamp_v;
  logic [1:0]         map_last;
  always_comb begin
    is_region = (req_q.func == FUNC_REGION_START);
    is_y      = is_region ? map_idx_q[1] : map_idx_q[0];
    mp        = is_y ? req_q.y_pos : req_q.x_pos;
    mh        = is_y ? req_q.half_height : req_q.half_width;
    morg      = is_y ? y_origin_q : x_origin_q;
    mscale    = is_y ? y_bins_per_unit_q : x_bins_per_unit_q;
    if (!is_region) begin
      mpos = 18'(mp);
    end else if (map_idx_q[0]) begin
      mpos = 18'(mp) + $signed({3'b000, mh});
    end else begin
      mpos = 18'(mp) - $signed({3'b000, mh});
    end
    moff = 19'(mpos) - 19'(morg);
    if (moff[18] || moff == 19'sd0) begin
      map_prod = '0;
    end else begin
      map_prod = 33'(moff[16:0]) * 33'(mscale);
    end
    mbin     = prod_q[32:8];
    mlim     = is_y ? MW'(lrow) : MW'(lcol);
    clamp_v  = (mbin > 25'(mlim)) ? mlim : MW'(mbin);
    map_last = is_region ? 2'd3 : 2'd1;
  end

  logic [LW-1:0] id_link;
  logic          in_pool;
  logic [BW-1:0] tgt;
  assign id_link = LW'(req_q.element_id) + LW'(1);
  assign in_pool = 32'(req_q.element_id) < POOL_SIZE;
  assign tgt     = {RW'(map_q[1]), CW'(map_q[0])};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Request sequencer.
  always_comb begin
    logic [CPW-1:0] ncolp;
    logic [RPW-1:0] nrow;
    logic           cached;
    elem_t          rec;

    state_d     = state_q;
    req_d       = req_q;
    rec_d       = rec_q;
    head_d      = head_q;
    map_idx_d   = map_idx_q;
    prod_d      = prod_q;
    map_d       = map_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    smin_col_d  = smin_col_q;
    smax_col_d  = smax_col_q;
    smin_row_d  = smin_row_q;
    smax_row_d  = smax_row_q;
    scol_d      = scol_q;
    srow_d      = srow_q;
    scur_d      = scur_q;
    ssucc_d     = ssucc_q;
    clr_cnt_d   = clr_cnt_q;
    clr_reply_d = clr_reply_q;
    b_we        = 1'b0;
    b_waddr     = '0;
    b_wdata     = '0;
    b_raddr     = '0;
    e_we        = 1'b0;
    e_waddr     = '0;
    e_wdata     = '0;
    e_raddr     = '0;
    ncolp       = scol_q + CPW'(1);
    nrow        = srow_q + RPW'(1);
    cached      = (scur_q != '0) && (e_rdata.succ != '0) && (ssucc_q != '0);
    rec         = e_rdata;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Sweep both memories back to empty.
      S_CLEAR: begin
        if (32'(clr_cnt_q) < BinDepth) begin
          b_we    = 1'b1;
          b_waddr = BW'(clr_cnt_q);
        end
        if (32'(clr_cnt_q) < POOL_SIZE) begin
          e_we    = 1'b1;
          e_waddr = EW'(clr_cnt_q);
        end
        if (clr_cnt_q == CLW'(ClrN - 1)) begin
          clr_reply_d = 1'b0;
          res_d       = '0;
          res_d.status = STATUS_OK;
          state_d     = clr_reply_q ? S_DONE : S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CLW'(1);
        end
      end

      // Take a request and fetch the element record it needs.
      S_IDLE: begin
        e_raddr = (in_req_i.func == FUNC_NEXT) ? lidx(scur_q) : EW'(in_req_i.element_id);
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.func == FUNC_CLEAR) begin
            clr_cnt_d   = '0;
            clr_reply_d = 1'b1;
            scur_d      = '0;
            ssucc_d     = '0;
            state_d     = S_CLEAR;
          end else begin
            state_d = S_ELEM;
          end
        end
      end

      // Decide on the request from the element record.
      S_ELEM: begin
        res_d = '0;
        res_d.status = STATUS_OK;
        map_idx_d = 2'd0;
        case (req_q.func)
          FUNC_INSERT_POINT, FUNC_INSERT_BIN: begin
            if (!in_pool) begin
              res_d.status = STATUS_NOT_PLACED;
              state_d = S_DONE;
            end else if (e_rdata.placed) begin
              res_d.status = STATUS_PLACED;
              state_d = S_DONE;
            end else if (req_q.func == FUNC_INSERT_POINT) begin
              state_d = S_MAP;
            end else if ((32'(req_q.bin_col) > 32'(lcol)) ||
                         (32'(req_q.bin_row) > 32'(lrow))) begin
              res_d.status = STATUS_BIN_RANGE;
              state_d = S_DONE;
            end else begin
              map_d[0] = MW'(req_q.bin_col);
              map_d[1] = MW'(req_q.bin_row);
              state_d  = S_LRD;
            end
          end
          FUNC_REMOVE, FUNC_MOVE: begin
            if (!in_pool || !e_rdata.placed) begin
              res_d.status = STATUS_NOT_PLACED;
              state_d = S_DONE;
            end else begin
              rec_d   = e_rdata;
              e_raddr = lidx(e_rdata.pred);
              state_d = S_UPV;
            end
          end
          FUNC_REGION_START: begin
            state_d = S_MAP;
          end
          FUNC_FULL_START: begin
            smin_col_d = '0;
            smax_col_d = lcol;
            smin_row_d = '0;
            smax_row_d = lrow;
            srow_d     = '0;
            scol_d     = '0;
            scur_d     = '0;
            ssucc_d    = '0;
            state_d    = S_DONE;
          end
          FUNC_NEXT: begin
            if (cached) begin
              scur_d  = ssucc_q;
              e_raddr = lidx(ssucc_q);
              state_d = S_NFOUND;
            end else begin
              state_d = S_NADV;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // Multiply stage of the bin mapping.
      S_MAP: begin
        prod_d  = map_prod;
        state_d = S_CLAMP;
      end

      // Clamp stage; after the last axis value start the scan or the link-in.
      S_CLAMP: begin
        map_d[map_idx_q] = clamp_v;
        if (map_idx_q == map_last) begin
          if (is_region) begin
            smin_col_d = CW'(map_q[0]);
            smax_col_d = CW'(map_q[1]);
            smin_row_d = RW'(map_q[2]);
            smax_row_d = RW'(clamp_v);
            srow_d     = RPW'(RW'(map_q[2]));
            scol_d     = CPW'(CW'(map_q[0]));
            scur_d     = '0;
            ssucc_d    = '0;
            res_d      = '0;
            res_d.status = STATUS_OK;
            state_d    = S_DONE;
          end else begin
            state_d = S_LRD;
          end
        end else begin
          map_idx_d = map_idx_q + 2'd1;
          state_d   = S_MAP;
        end
      end

      // Unlink: predecessor takes our successor.
      S_UPV: begin
        rec      = e_rdata;
        rec.succ = rec_q.succ;
        e_we     = (rec_q.pred != '0);
        e_waddr  = lidx(rec_q.pred);
        e_wdata  = rec;
        e_raddr  = lidx(rec_q.succ);
        state_d  = S_UNX;
      end

      // Unlink: successor takes our predecessor.
      S_UNX: begin
        rec      = e_rdata;
        rec.pred = rec_q.pred;
        e_we     = (rec_q.succ != '0);
        e_waddr  = lidx(rec_q.succ);
        e_wdata  = rec;
        b_raddr  = {rec_q.row, rec_q.col};
        state_d  = S_UHEAD;
      end

      // Unlink: move the bin head on and drop the element.
      S_UHEAD: begin
        if (b_rdata == id_link) begin
          b_we    = 1'b1;
          b_waddr = {rec_q.row, rec_q.col};
          b_wdata = rec_q.succ;
        end
        e_we    = 1'b1;
        e_waddr = EW'(req_q.element_id);
        e_wdata = '0;
        if (req_q.func == FUNC_MOVE) begin
          map_idx_d = 2'd0;
          state_d   = S_MAP;
        end else begin
          res_d = '0;
          res_d.status = STATUS_OK;
          state_d = S_DONE;
        end
      end

      // Link-in: fetch the target bin head.
      S_LRD: begin
        b_raddr = tgt;
        state_d = S_LHEAD;
      end

      // Link-in: new head, element record, fetch the old head's record.
      S_LHEAD: begin
        head_d      = b_rdata;
        b_we        = 1'b1;
        b_waddr     = tgt;
        b_wdata     = id_link;
        rec.placed  = 1'b1;
        rec.row     = RW'(map_q[1]);
        rec.col     = CW'(map_q[0]);
        rec.succ    = b_rdata;
        rec.pred    = '0;
        e_we        = 1'b1;
        e_waddr     = EW'(req_q.element_id);
        e_wdata     = rec;
        e_raddr     = lidx(b_rdata);
        state_d     = S_LFIX;
      end

      // Link-in: old head points back to the new one.
      S_LFIX: begin
        rec      = e_rdata;
        rec.pred = id_link;
        e_we     = (head_q != '0);
        e_waddr  = lidx(head_q);
        e_wdata  = rec;
        res_d    = '0;
        res_d.status = STATUS_OK;
        state_d  = S_DONE;
      end

      // Scan: step to the next bin of the rectangle.
      S_NADV: begin
        if (32'(srow_q) > 32'(smax_row_q)) begin
          scur_d  = '0;
          ssucc_d = '0;
          res_d   = '0;
          res_d.status = STATUS_DONE;
          state_d = S_DONE;
        end else if (32'(ncolp) > 32'(smax_col_q) + 1) begin
          srow_d = nrow;
          scol_d = ncolp;
          if (32'(nrow) > 32'(smax_row_q)) begin
            scur_d  = '0;
            ssucc_d = '0;
            res_d   = '0;
            res_d.status = STATUS_DONE;
            state_d = S_DONE;
          end else begin
            scol_d  = CPW'(smin_col_q) + CPW'(1);
            b_raddr = {RW'(nrow), smin_col_q};
            state_d = S_NBIN;
          end
        end else begin
          scol_d  = ncolp;
          b_raddr = {RW'(srow_q), CW'(ncolp - CPW'(1))};
          state_d = S_NBIN;
        end
      end

      // Scan: look at the bin head.
      S_NBIN: begin
        if (b_rdata != '0) begin
          scur_d  = b_rdata;
          e_raddr = lidx(b_rdata);
          state_d = S_NFOUND;
        end else begin
          state_d = S_NADV;
        end
      end

      // Scan: report the element and cache its successor.
      S_NFOUND: begin
        ssucc_d = e_rdata.succ;
        res_d   = '0;
        res_d.status        = STATUS_OK;
        res_d.found_element = 8'(scur_q - LW'(1));
        if (e_rdata.placed) begin
          res_d.found_col = 6'(e_rdata.col);
          res_d.found_row = 6'(e_rdata.row);
        end
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      smin_col_q  <= '0;
      smax_col_q  <= '0;
      smin_row_q  <= '0;
      smax_row_q  <= '0;
      scol_q      <= CPW'(1);
      srow_q      <= '0;
      scur_q      <= '0;
      ssucc_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      smin_col_q  <= smin_col_d;
      smax_col_q  <= smax_col_d;
      smin_row_q  <= smin_row_d;
      smax_row_q  <= smax_row_d;
      scol_q      <= scol_d;
      srow_q      <= srow_d;
      scur_q      <= scur_d;
      ssucc_q     <= ssucc_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rec_q     <= rec_d;
    head_q    <= head_d;
    map_idx_q <= map_idx_d;
    prod_q    <= prod_d;
    map_q     <= map_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_in_use_q  <= 7'd64;
      rows_in_use_q     <= 7'd64;
      x_origin_q        <= '0;
      y_origin_q        <= '0;
      x_bins_per_unit_q <= 16'd256;
      y_bins_per_unit_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COLUMNS: columns_in_use_q  <= cfg_wdata_i[6:0];
        REG_ROWS:    rows_in_use_q     <= cfg_wdata_i[6:0];
        REG_X_ORG:   x_origin_q        <= $signed(cfg_wdata_i);
        REG_Y_ORG:   y_origin_q        <= $signed(cfg_wdata_i);
        REG_X_SCALE: x_bins_per_unit_q <= cfg_wdata_i;
        REG_Y_SCALE: y_bins_per_unit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/gsh_chk.sv]
`include "grid_spatial_hash_bins_assert.svh"

module gsh_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gsh_pkg::rsp_t out_rsp_o
);
  import gsh_pkg::*;

  logic in_take;
  logic out_held;
  logic stray_fields;

  // Handshake and field summaries used by the checks below.
  assign in_take      = in_valid_i && !in_stall_o;
  assign out_held     = out_valid_o && out_stall_i;
  assign stray_fields = out_valid_o && (out_rsp_o.status != STATUS_OK) &&
                        (out_rsp_o.found_element != 8'd0 || out_rsp_o.found_col != 6'd0 ||
                         out_rsp_o.found_row != 6'd0);

  // A stalled result stays offered unchanged.
  `GSH_ASSERT(a_out_hold, clk_i, rst_ni,
    out_held |=> out_valid_o && $stable(out_rsp_o), "stalled result changed")

  // A request is worked on alone: the input stalls right after a request.
  `GSH_ASSERT(a_busy_after_req, clk_i, rst_ni, in_take |=> in_stall_o, "request taken while busy")

  // Only a result with status OK may carry element and bin fields.
  `GSH_ASSERT_NEVER(a_fields_zero, clk_i, rst_ni, stray_fields, "stray found fields")

  // A new result only comes out of work in progress.
  `GSH_ASSERT(a_result_from_work, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(in_stall_o), "result without a request at work")

endmodule

bind grid_spatial_hash_bins gsh_chk u_gsh_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsh_pkg::*;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int NBIN = NCOL * NROW;
  localparam int NPOOL = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  grid_spatial_hash_bins dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // Mirror of the grid contents: links hold element id + 1, zero for none.
  logic [8:0]  head_of_bin [NBIN];
  logic [8:0]  next_in_bin [NPOOL];
  logic [8:0]  prev_in_bin [NPOOL];
  logic [12:0] home_bin    [NPOOL];  // bin + 1, zero when unplaced
  int          walk_min_col, walk_max_col, walk_min_row, walk_max_row;
  int          walk_col, walk_row;
  logic [8:0]  walk_cur, walk_succ;

  // Mirror of the configuration registers.
  logic [6:0]         cfg_cols, cfg_rows;
  logic signed [15:0] cfg_x_org, cfg_y_org;
  logic [15:0]        cfg_x_scale, cfg_y_scale;

  rsp_t pending_rsp[$];
  int   fails = 0;
  int   hold_asked = 0;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  stim_row_t stim_tab[$];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #300_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int cols_eff();
    return (cfg_cols < 1) ? 1 : (cfg_cols > NCOL) ? NCOL : int'(cfg_cols);
  endfunction

  function automatic int rows_eff();
    return (cfg_rows < 1) ? 1 : (cfg_rows > NROW) ? NROW : int'(cfg_rows);
  endfunction

  // Coordinate to bin along one axis, truncated and clamped.
  function automatic int axis_to_bin(longint pos, longint org, longint scale, int count);
    longint off, b;
    off = pos - org;
    if (off <= 0) return 0;
    b = (off * scale) >>> 8;
    if (b > count - 1) return count - 1;
    return int'(b);
  endfunction

  function automatic int point_to_bin(longint x, longint y);
    int c, r;
    c = axis_to_bin(x, cfg_x_org, cfg_x_scale, cols_eff());
    r = axis_to_bin(y, cfg_y_org, cfg_y_scale, rows_eff());
    return r * NCOL + c;
  endfunction

  function automatic void place_elem(int id, int b);
    logic [8:0] h;
    h = head_of_bin[b];
    next_in_bin[id] = h;
    prev_in_bin[id] = '0;
    if (h != 0) prev_in_bin[h - 1] = 9'(id + 1);
    head_of_bin[b] = 9'(id + 1);
    home_bin[id] = 13'(b + 1);
  endfunction

  function automatic void unplace_elem(int id);
    int b;
    logic [8:0] nx, pv;
    b = int'(home_bin[id]) - 1;
    nx = next_in_bin[id];
    pv = prev_in_bin[id];
    if (pv != 0) next_in_bin[pv - 1] = nx;
    if (nx != 0) prev_in_bin[nx - 1] = pv;
    if (head_of_bin[b] == 9'(id + 1)) head_of_bin[b] = nx;
    next_in_bin[id] = '0;
    prev_in_bin[id] = '0;
    home_bin[id] = '0;
  endfunction

  function automatic void start_walk(int c0, int c1, int r0, int r1);
    walk_min_col = c0;
    walk_max_col = c1;
    walk_min_row = r0;
    walk_max_row = r1;
    walk_row = r0;
    walk_col = c0 - 1;
    walk_cur = '0;
    walk_succ = '0;
  endfunction

  function automatic void wipe_grid();
    for (int i = 0; i < NBIN; i++) head_of_bin[i] = '0;
    for (int i = 0; i < NPOOL; i++) begin
      next_in_bin[i] = '0;
      prev_in_bin[i] = '0;
      home_bin[i] = '0;
    end
    walk_cur = '0;
    walk_succ = '0;
  endfunction

  // Applies one request to the mirror and returns the result it should give.
  function automatic rsp_t grid_apply(req_t r);
    rsp_t o;
    int id, b;
    longint x, y, hw, hh;
    logic [8:0] cur;
    o = '0;
    o.status = STATUS_OK;
    id = int'(r.element_id);
    x = r.x_pos;
    y = r.y_pos;
    hw = r.half_width;
    hh = r.half_height;
    case (r.func)
      FUNC_INSERT_POINT, FUNC_INSERT_BIN: begin
        if (home_bin[id] != 0) o.status = STATUS_PLACED;
        else if (r.func == FUNC_INSERT_POINT) place_elem(id, point_to_bin(x, y));
        else if (int'(r.bin_col) >= cols_eff() || int'(r.bin_row) >= rows_eff())
          o.status = STATUS_BIN_RANGE;
        else place_elem(id, int'(r.bin_row) * NCOL + int'(r.bin_col));
      end
      FUNC_REMOVE, FUNC_MOVE: begin
        if (home_bin[id] == 0) o.status = STATUS_NOT_PLACED;
        else begin
          unplace_elem(id);
          if (r.func == FUNC_MOVE) place_elem(id, point_to_bin(x, y));
        end
      end
      FUNC_REGION_START: begin
        start_walk(axis_to_bin(x - hw, cfg_x_org, cfg_x_scale, cols_eff()),
                   axis_to_bin(x + hw, cfg_x_org, cfg_x_scale, cols_eff()),
                   axis_to_bin(y - hh, cfg_y_org, cfg_y_scale, rows_eff()),
                   axis_to_bin(y + hh, cfg_y_org, cfg_y_scale, rows_eff()));
      end
      FUNC_FULL_START: start_walk(0, cols_eff() - 1, 0, rows_eff() - 1);
      FUNC_NEXT: begin
        cur = walk_cur;
        // The cached successor only counts while the live link still points on.
        if (cur != 0 && next_in_bin[cur - 1] != 0 && walk_succ != 0) begin
          cur = walk_succ;
        end else begin
          cur = '0;
          while (cur == 0 && walk_row <= walk_max_row) begin
            walk_col++;
            if (walk_col > walk_max_col) begin
              walk_row++;
              walk_col = walk_min_col;
            end
            if (walk_row <= walk_max_row) cur = head_of_bin[walk_row * NCOL + walk_col];
          end
        end
        walk_cur = cur;
        if (cur == 0) begin
          walk_succ = '0;
          o.status = STATUS_DONE;
        end else begin
          walk_succ = next_in_bin[cur - 1];
          o.found_element = 8'(cur - 1);
          if (home_bin[cur - 1] != 0) begin
            b = int'(home_bin[cur - 1]) - 1;
            o.found_col = 6'(b % NCOL);
            o.found_row = 6'(b / NCOL);
          end
        end
      end
      default: wipe_grid();
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(func_e f, int id, int x, int y, int c, int r, int hw, int hh);
    req_t q;
    q.func = f;
    q.element_id = 8'(id);
    q.x_pos = 16'(x);
    q.y_pos = 16'(y);
    q.bin_col = 6'(c);
    q.bin_row = 6'(r);
    q.half_width = 15'(hw);
    q.half_height = 15'(hh);
    return q;
  endfunction

  function automatic void add_row(req_t q, bit typed, status_e s);
    stim_row_t row;
    row.req = q;
    row.typed = typed;
    row.rsp = '0;
    row.rsp.status = s;
    stim_tab.push_back(row);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLUMNS: cfg_cols = val[6:0];
      REG_ROWS:    cfg_rows = val[6:0];
      REG_X_ORG:   cfg_x_org = val;
      REG_Y_ORG:   cfg_y_org = val;
      REG_X_SCALE: cfg_x_scale = val;
      default:     cfg_y_scale = val;
    endcase
  endtask

  task automatic write_all(int c, int r, int xo, int yo, int xs, int ys);
    write_reg(REG_COLUMNS, 16'(c));
    write_reg(REG_ROWS, 16'(r));
    write_reg(REG_X_ORG, 16'(xo));
    write_reg(REG_Y_ORG, 16'(yo));
    write_reg(REG_X_SCALE, 16'(xs));
    write_reg(REG_Y_SCALE, 16'(ys));
  endtask

  // Offers one request and waits for it to be taken; the mirror follows on acceptance.
  task automatic send_req(req_t q, bit typed, rsp_t typed_rsp);
    rsp_t p;
    in_valid <= 1'b1;
    in_req <= q;
    do @(posedge clk); while (in_stall);
    p = grid_apply(q);
    pending_rsp.push_back(typed ? typed_rsp : p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t random_req();
    int pick, id, xo, yo;
    func_e f;
    pick = $urandom_range(0, 99);
    if (pick < 20) f = FUNC_INSERT_POINT;
    else if (pick < 33) f = FUNC_INSERT_BIN;
    else if (pick < 43) f = FUNC_REMOVE;
    else if (pick < 53) f = FUNC_MOVE;
    else if (pick < 60) f = FUNC_REGION_START;
    else if (pick < 64) f = FUNC_FULL_START;
    else if (pick < 98) f = FUNC_NEXT;
    else f = FUNC_CLEAR;
    id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    if ($urandom_range(0, 4) == 0) begin
      xo = $urandom_range(0, 65535);
      yo = $urandom_range(0, 65535);
    end else begin
      xo = int'(cfg_x_org) + $urandom_range(0, 80) - 10;
      yo = int'(cfg_y_org) + $urandom_range(0, 80) - 10;
    end
    return mk_req(f, id, xo, yo,
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 7),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 7),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 20),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 20));
  endfunction

  // Result checker: every taken result is matched against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d", out_rsp.status);
        fails++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          fails++;
        end
        if (out_rsp.found_element !== want.found_element) begin
          $error("found_element: expected %0d, got %0d", want.found_element,
                 out_rsp.found_element);
          fails++;
        end
        if (out_rsp.found_col !== want.found_col) begin
          $error("found_col: expected %0d, got %0d", want.found_col, out_rsp.found_col);
          fails++;
        end
        if (out_rsp.found_row !== want.found_row) begin
          $error("found_row: expected %0d, got %0d", want.found_row, out_rsp.found_row);
          fails++;
        end
      end
    end
  end

  // Result side back-pressure: shifting stall density, plus one long hold on demand.
  initial begin
    int mode, span, hold_left, hold_seen;
    mode = 0;
    span = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = 400;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 120);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  // Main sequence: directed table, then random phases under several grid settings.
  initial begin
    int burst, wait_cnt;
    rsp_t no_rsp;
    no_rsp = '0;
    cfg_cols = 7'd64;
    cfg_rows = 7'd64;
    cfg_x_org = '0;
    cfg_y_org = '0;
    cfg_x_scale = 16'd256;
    cfg_y_scale = 16'd256;
    wipe_grid();
    walk_min_col = 0;
    walk_max_col = 0;
    walk_min_row = 0;
    walk_max_row = 0;
    walk_col = 0;
    walk_row = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_all(40, 64, 0, 0, 256, 256);

    add_row(mk_req(FUNC_NEXT, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_DONE);
    add_row(mk_req(FUNC_REMOVE, 5, 0, 0, 0, 0, 0, 0), 1, STATUS_NOT_PLACED);
    add_row(mk_req(FUNC_MOVE, 5, 3, 3, 0, 0, 0, 0), 1, STATUS_NOT_PLACED);
    add_row(mk_req(FUNC_INSERT_POINT, 0, -32768, -32768, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_INSERT_POINT, 255, 32767, 32767, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_INSERT_POINT, 0, 5, 5, 0, 0, 0, 0), 1, STATUS_PLACED);
    add_row(mk_req(FUNC_INSERT_BIN, 7, 0, 0, 63, 0, 0, 0), 1, STATUS_BIN_RANGE);
    add_row(mk_req(FUNC_INSERT_BIN, 7, 0, 0, 39, 63, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_INSERT_BIN, 8, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_INSERT_BIN, 8, 0, 0, 1, 1, 0, 0), 1, STATUS_PLACED);
    add_row(mk_req(FUNC_FULL_START, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
    for (int i = 0; i < 5; i++) add_row(mk_req(FUNC_NEXT, 0, 0, 0, 0, 0, 0, 0), 0, STATUS_OK);
    add_row(mk_req(FUNC_MOVE, 8, 100, 5, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_REGION_START, 0, 0, 0, 0, 0, 32767, 32767), 1, STATUS_OK);
    for (int i = 0; i < 3; i++) add_row(mk_req(FUNC_NEXT, 0, 0, 0, 0, 0, 0, 0), 0, STATUS_OK);
    add_row(mk_req(FUNC_REMOVE, 255, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_OK);
    add_row(mk_req(FUNC_NEXT, 0, 0, 0, 0, 0, 0, 0), 0, STATUS_OK);
    add_row(mk_req(FUNC_REMOVE, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_NOT_PLACED);
    foreach (stim_tab[i]) send_req(stim_tab[i].req, stim_tab[i].typed, stim_tab[i].rsp);
    wait_drained();

    // Each phase starts after a drain, so settings change only while the block is idle.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_all(8, 8, 0, 0, 256, 256);
        1: write_all(1, 1, -32768, 32767, 0, 65535);
        2: write_all(0, 127, 32767, -32768, 65535, 0);
        3: write_all(64, 64, $urandom_range(0, 65535), $urandom_range(0, 65535), 512, 128);
        4: write_all($urandom_range(1, 16), $urandom_range(1, 16),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
        5: write_all(5, 3, -100, 200, 4096, 64);
        default: write_all(12, 10, 0, 0, 1024, 1024);
      endcase
      for (int n = 0; n < 90; ) begin
        burst = $urandom_range(1, 12);
        if (ph == 2 && hold_asked == 0 && n >= 30) hold_asked++;
        for (int k = 0; k < burst; k++) begin
          send_req(random_req(), 0, no_rsp);
          n++;
        end
        wait_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        if (wait_cnt != 0) begin
          in_valid <= 1'b0;
          repeat (wait_cnt) @(posedge clk);
        end
      end
      wait_drained();
    end

    wait_cnt = 0;
    while (pending_rsp.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    if (fails == 0 && pending_rsp.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
